// File: rtl/core/br1rd_pkg.sv
// Shared types and constants for the ByteRun1 row decoder.
`default_nettype none

package br1rd_pkg;

	localparam int unsigned RegIdxW = 1;
	localparam int unsigned CfgDataW = 16;

	localparam logic [RegIdxW-1:0] REG_COMPRESSION = 1'd0;
	localparam logic [RegIdxW-1:0] REG_BYTES_PER_ROW = 1'd1;

	localparam logic [7:0] MODE_RAW = 8'd0;
	localparam logic [7:0] MODE_BYTERUN1 = 8'd1;
	localparam logic [7:0] COMPRESSION_RST = 8'd1;
	localparam logic [15:0] BYTES_PER_ROW_RST = 16'd40;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END = 1'b1;

	localparam logic [7:0] CTRL_SKIP = 8'h80;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_EARLY_END = 2'd2;
	localparam logic [1:0] STAT_BAD_MODE = 2'd3;

	typedef enum logic [1:0] {
		PH_CONTROL,
		PH_COPY,
		PH_REPEAT
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_REPEAT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rep_start;
		logic rep_last;
		logic slot_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/byterun1_row_decoder_top.sv
// Top level of the ByteRun1 (PackBits) bitplane row decoder.
`default_nettype none

// Decodes one compressed byte per accepted item into results of up to two bytes.
// Raw and literal bytes each give a one-byte result; a control byte gives none
// unless it overflows the row. The data byte of a repeat drains a run of n bytes
// as results of up to two bytes each through the result register, which waits on
// out_ready, and no item is accepted while the run drains. Any configuration write
// restarts the decoder with a full row count.
module byterun1_row_decoder_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [br1rd_pkg::RegIdxW-1:0]       cfg_index,
	input  wire logic [br1rd_pkg::CfgDataW-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                command,
	input  wire logic [7:0]                          data_byte,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [7:0]                               byte_first,
	output logic [7:0]                               byte_second,
	output logic [1:0]                               valid_count,
	output logic                                     row_end,
	output logic [1:0]                               status,
	output logic                                     last
);

	br1rd_pkg::ctrl_cmd_t cmd;
	br1rd_pkg::dp_stat_t  stat;

	br1rd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	br1rd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (command),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_first  (byte_first),
		.byte_second (byte_second),
		.valid_count (valid_count),
		.row_end     (row_end),
		.status      (status),
		.last        (last)
	);

endmodule

`default_nettype wire

// File: rtl/core/br1rd_ctrl.sv
// Controller state machine: sequences item intake and repeat-run draining.
`default_nettype none

module br1rd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire br1rd_pkg::dp_stat_t  stat,
	output br1rd_pkg::ctrl_cmd_t      cmd
);

	br1rd_pkg::ctrl_state_t state_q;
	br1rd_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= br1rd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			br1rd_pkg::ST_IDLE: begin
				if (in_valid && stat.slot_free && stat.rep_start) begin
					state_d = br1rd_pkg::ST_REPEAT;
				end
			end
			br1rd_pkg::ST_REPEAT: begin
				if (stat.slot_free && stat.rep_last) begin
					state_d = br1rd_pkg::ST_IDLE;
				end
			end
			default: state_d = br1rd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			br1rd_pkg::ST_IDLE: begin
				in_ready = stat.slot_free;
				cmd.accept = in_valid && stat.slot_free;
			end
			br1rd_pkg::ST_REPEAT: begin
				cmd.emit = stat.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_accept_and_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.emit))
		else $error("accept and emit in the same cycle");
	a_repeat_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == br1rd_pkg::ST_REPEAT) |-> !in_ready)
		else $error("input taken while a run drains");
`endif

endmodule

`default_nettype wire

// File: rtl/core/br1rd_dpath.sv
// Datapath: registers, row and run counters, and the result register.
`default_nettype none

module br1rd_dpath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [br1rd_pkg::RegIdxW-1:0]          cfg_index,
	input  wire logic [br1rd_pkg::CfgDataW-1:0]         cfg_data,
	input  wire logic                                   command,
	input  wire logic [7:0]                             data_byte,
	input  wire br1rd_pkg::ctrl_cmd_t                   cmd,
	output br1rd_pkg::dp_stat_t                         stat,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [7:0]                                  byte_first,
	output logic [7:0]                                  byte_second,
	output logic [1:0]                                  valid_count,
	output logic                                        row_end,
	output logic [1:0]                                  status,
	output logic                                        last
);

	logic [7:0]        compression_q;
	logic [15:0]       bytes_per_row_q;
	br1rd_pkg::phase_t phase_q, phase_d;
	logic [7:0]        run_left_q, run_left_d;
	logic [15:0]       row_left_q, row_left_d;
	logic [7:0]        rep_byte_q, rep_byte_d;
	logic [7:0]        rep_left_q, rep_left_d;
	logic              out_valid_q;

	logic [7:0]  r_first, r_second;
	logic [1:0]  r_count, r_status;
	logic        r_rend, r_last, r_load;
	logic [7:0]  first_q, second_q;
	logic [1:0]  count_q, status_q;
	logic        rend_q, last_q;

	logic [15:0] row_len;
	logic [15:0] new_bpr;
	logic [15:0] new_len;
	logic [1:0]  take;
	logic [7:0]  n_lit;
	logic [7:0]  n_rep;

	assign row_len = (bytes_per_row_q == '0) ? 16'd1 : bytes_per_row_q;
	assign new_bpr = (cfg_index == br1rd_pkg::REG_BYTES_PER_ROW) ? cfg_data : bytes_per_row_q;
	assign new_len = (new_bpr == '0) ? 16'd1 : new_bpr;
	assign take = (rep_left_q >= 8'd2) ? 2'd2 : 2'd1;
	assign n_lit = {1'b0, data_byte[6:0]} + 8'd1;
	assign n_rep = ~data_byte + 8'd2;

	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.rep_start = (compression_q == br1rd_pkg::MODE_BYTERUN1)
		&& (command == br1rd_pkg::CMD_DATA) && (phase_q == br1rd_pkg::PH_REPEAT);
	assign stat.rep_last = (rep_left_q <= 8'd2);

	always_comb begin
		phase_d = phase_q;
		run_left_d = run_left_q;
		row_left_d = row_left_q;
		rep_byte_d = rep_byte_q;
		rep_left_d = rep_left_q;
		r_load = 1'b0;
		r_first = '0;
		r_second = '0;
		r_count = '0;
		r_rend = 1'b0;
		r_status = br1rd_pkg::STAT_OK;
		r_last = 1'b1;
		if (cfg_we) begin
			phase_d = br1rd_pkg::PH_CONTROL;
			run_left_d = '0;
			row_left_d = new_len;
		end else if (cmd.accept) begin
			if (compression_q > br1rd_pkg::MODE_BYTERUN1) begin
				r_load = 1'b1;
				r_status = br1rd_pkg::STAT_BAD_MODE;
				phase_d = br1rd_pkg::PH_CONTROL;
				run_left_d = '0;
				row_left_d = row_len;
			end else if (command == br1rd_pkg::CMD_END) begin
				if (phase_q != br1rd_pkg::PH_CONTROL || row_left_q != row_len) begin
					r_load = 1'b1;
					r_status = br1rd_pkg::STAT_EARLY_END;
					phase_d = br1rd_pkg::PH_CONTROL;
					run_left_d = '0;
					row_left_d = row_len;
				end
			end else if (compression_q == br1rd_pkg::MODE_RAW
				|| phase_q == br1rd_pkg::PH_COPY) begin
				r_load = 1'b1;
				r_first = data_byte;
				r_count = 2'd1;
				r_rend = (row_left_q == 16'd1);
				row_left_d = r_rend ? row_len : row_left_q - 16'd1;
				if (phase_q == br1rd_pkg::PH_COPY) begin
					run_left_d = run_left_q - 8'd1;
					if (run_left_q == 8'd1) begin
						phase_d = br1rd_pkg::PH_CONTROL;
					end
				end
			end else if (phase_q == br1rd_pkg::PH_REPEAT) begin
				rep_byte_d = data_byte;
				rep_left_d = run_left_q;
				phase_d = br1rd_pkg::PH_CONTROL;
				run_left_d = '0;
			end else if (data_byte != br1rd_pkg::CTRL_SKIP) begin
				if (!data_byte[7]) begin
					if ({8'd0, n_lit} > row_left_q) begin
						r_load = 1'b1;
						r_status = br1rd_pkg::STAT_OVERFLOW;
						row_left_d = row_len;
					end else begin
						phase_d = br1rd_pkg::PH_COPY;
						run_left_d = n_lit;
					end
				end else begin
					if ({8'd0, n_rep} > row_left_q) begin
						r_load = 1'b1;
						r_status = br1rd_pkg::STAT_OVERFLOW;
						row_left_d = row_len;
					end else begin
						phase_d = br1rd_pkg::PH_REPEAT;
						run_left_d = n_rep;
					end
				end
			end
		end else if (cmd.emit) begin
			r_load = 1'b1;
			r_first = rep_byte_q;
			r_second = (take == 2'd2) ? rep_byte_q : 8'd0;
			r_count = take;
			r_rend = (row_left_q == {14'd0, take});
			r_last = (rep_left_q == {6'd0, take});
			row_left_d = r_rend ? row_len : row_left_q - {14'd0, take};
			rep_left_d = rep_left_q - {6'd0, take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compression_q <= br1rd_pkg::COMPRESSION_RST;
			bytes_per_row_q <= br1rd_pkg::BYTES_PER_ROW_RST;
			phase_q <= br1rd_pkg::PH_CONTROL;
			run_left_q <= '0;
			row_left_q <= br1rd_pkg::BYTES_PER_ROW_RST;
			rep_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == br1rd_pkg::REG_COMPRESSION) begin
				compression_q <= cfg_data[7:0];
			end
			if (cfg_we && cfg_index == br1rd_pkg::REG_BYTES_PER_ROW) begin
				bytes_per_row_q <= cfg_data;
			end
			phase_q <= phase_d;
			run_left_q <= run_left_d;
			row_left_q <= row_left_d;
			rep_left_q <= rep_left_d;
			if (r_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rep_byte_q <= rep_byte_d;
		if (r_load) begin
			first_q <= r_first;
			second_q <= r_second;
			count_q <= r_count;
			rend_q <= r_rend;
			status_q <= r_status;
			last_q <= r_last;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_first = first_q;
	assign byte_second = second_q;
	assign valid_count = count_q;
	assign row_end = rend_q;
	assign status = status_q;
	assign last = last_q;

`ifndef NO_ASSERTIONS
	a_row_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		row_left_q != '0)
		else $error("row count reached zero without restart");
	a_copy_has_run: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == br1rd_pkg::PH_COPY) |-> (run_left_q != '0))
		else $error("copy phase with empty run");
	a_emit_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (rep_left_q != '0) && ({8'd0, rep_left_q} <= row_left_q))
		else $error("repeat emit without bytes left or past row end");
`endif

endmodule

`default_nettype wire

// File: sim/byterun1_row_decoder_top_tb.sv
// Testbench for the ByteRun1 row decoder: directed and random streams checked against a predictor.
`timescale 1ns / 1ps

module byterun1_row_decoder_top_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic [1:0] valid_count;
		logic       row_end;
		logic [1:0] status;
		logic       last;
	} decoded_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [br1rd_pkg::RegIdxW-1:0]  cfg_index = '0;
	logic [br1rd_pkg::CfgDataW-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           command = br1rd_pkg::CMD_DATA;
	logic [7:0]                     data_byte = 8'd0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [7:0]                     byte_first;
	logic [7:0]                     byte_second;
	logic [1:0]                     valid_count;
	logic                           row_end;
	logic [1:0]                     status;
	logic                           last;

	byterun1_row_decoder_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_first(byte_first),
		.byte_second(byte_second),
		.valid_count(valid_count),
		.row_end(row_end),
		.status(status),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// decoder state as predicted
	logic [7:0]          cur_mode = br1rd_pkg::COMPRESSION_RST;
	logic [15:0]         cur_row_bytes = br1rd_pkg::BYTES_PER_ROW_RST;
	br1rd_pkg::phase_t   dec_phase = br1rd_pkg::PH_CONTROL;
	logic [7:0]          dec_run = 8'd0;
	logic [15:0]         dec_row_left = br1rd_pkg::BYTES_PER_ROW_RST;

	decoded_t decoded_q[$];
	decoded_t want;

	int fail_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int writes_done = 0;
	int rows_done = 0;
	int errors_predicted = 0;
	int burst_left = 5;
	int stall_cycles = 0;
	logic [9:0] rx_tick = '0;

	function automatic logic [15:0] row_len();
		return (cur_row_bytes == 16'd0) ? 16'd1 : cur_row_bytes;
	endfunction

	function automatic void restart_row();
		dec_phase = br1rd_pkg::PH_CONTROL;
		dec_run = 8'd0;
		dec_row_left = row_len();
	endfunction

	function automatic logic take_bytes(input logic [15:0] n);
		dec_row_left = dec_row_left - n;
		if (dec_row_left == 16'd0) begin
			dec_row_left = row_len();
			rows_done++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void push_result(input logic [7:0] b0, input logic [7:0] b1,
			input logic [1:0] cnt, input logic rend, input logic [1:0] st, input logic lst);
		decoded_t d;
		d.byte_first = b0;
		d.byte_second = b1;
		d.valid_count = cnt;
		d.row_end = rend;
		d.status = st;
		d.last = lst;
		decoded_q.push_back(d);
	endfunction

	function automatic void report_error(input logic [1:0] st);
		push_result(8'd0, 8'd0, 2'd0, 1'b0, st, 1'b1);
		errors_predicted++;
		restart_row();
	endfunction

	function automatic void decode_byte(input logic cmd, input logic [7:0] b);
		int n;
		int left;
		int take;
		logic rend;
		if (cur_mode != br1rd_pkg::MODE_RAW && cur_mode != br1rd_pkg::MODE_BYTERUN1) begin
			report_error(br1rd_pkg::STAT_BAD_MODE);
			return;
		end
		if (cmd == br1rd_pkg::CMD_END) begin
			if (dec_phase != br1rd_pkg::PH_CONTROL || dec_row_left != row_len())
				report_error(br1rd_pkg::STAT_EARLY_END);
			return;
		end
		if (cur_mode == br1rd_pkg::MODE_RAW) begin
			rend = take_bytes(16'd1);
			push_result(b, 8'd0, 2'd1, rend, br1rd_pkg::STAT_OK, 1'b1);
			return;
		end
		case (dec_phase)
			br1rd_pkg::PH_COPY: begin
				rend = take_bytes(16'd1);
				dec_run = dec_run - 8'd1;
				if (dec_run == 8'd0)
					dec_phase = br1rd_pkg::PH_CONTROL;
				push_result(b, 8'd0, 2'd1, rend, br1rd_pkg::STAT_OK, 1'b1);
			end
			br1rd_pkg::PH_REPEAT: begin
				left = int'(dec_run);
				while (left > 0) begin
					take = (left >= 2) ? 2 : 1;
					left -= take;
					rend = (left == 0) ? take_bytes(16'(dec_run)) : 1'b0;
					push_result(b, (take == 2) ? b : 8'd0, 2'(take), rend,
						br1rd_pkg::STAT_OK, left == 0);
				end
				dec_phase = br1rd_pkg::PH_CONTROL;
				dec_run = 8'd0;
			end
			default: begin
				if (b == br1rd_pkg::CTRL_SKIP)
					return;
				n = b[7] ? 257 - int'(b) : int'(b) + 1;
				if (n > int'(dec_row_left)) begin
					report_error(br1rd_pkg::STAT_OVERFLOW);
					return;
				end
				dec_phase = b[7] ? br1rd_pkg::PH_REPEAT : br1rd_pkg::PH_COPY;
				dec_run = 8'(n);
			end
		endcase
	endfunction

	task automatic send_item(input logic cmd, input logic [7:0] b);
		command <= cmd;
		data_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		decode_byte(cmd, b);
		items_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 10);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_reg(input logic [br1rd_pkg::RegIdxW-1:0] idx,
			input logic [br1rd_pkg::CfgDataW-1:0] val);
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == br1rd_pkg::REG_COMPRESSION)
			cur_mode = val[7:0];
		else
			cur_row_bytes = val;
		restart_row();
		writes_done++;
	endtask

	task automatic set_config(input logic [7:0] mode, input logic [15:0] bpr);
		write_reg(br1rd_pkg::REG_COMPRESSION, {8'($urandom), mode});
		write_reg(br1rd_pkg::REG_BYTES_PER_ROW, bpr);
	endtask

	task automatic test_reset_defaults();
		send_item(br1rd_pkg::CMD_DATA, 8'h02);
		send_item(br1rd_pkg::CMD_DATA, 8'h00);
		send_item(br1rd_pkg::CMD_DATA, 8'h7F);
		send_item(br1rd_pkg::CMD_DATA, 8'hFF);
		send_item(br1rd_pkg::CMD_DATA, br1rd_pkg::CTRL_SKIP);
		send_item(br1rd_pkg::CMD_DATA, 8'hFD);
		send_item(br1rd_pkg::CMD_DATA, 8'hAA);
		send_item(br1rd_pkg::CMD_END, 8'h00);
		send_item(br1rd_pkg::CMD_END, 8'hFF);
		send_item(br1rd_pkg::CMD_DATA, 8'h81);
		send_item(br1rd_pkg::CMD_DATA, 8'h01);
		send_item(br1rd_pkg::CMD_END, 8'h00);
	endtask

	task automatic test_row_limits();
		set_config(br1rd_pkg::MODE_BYTERUN1, 16'd0);
		send_item(br1rd_pkg::CMD_DATA, 8'h00);
		send_item(br1rd_pkg::CMD_DATA, 8'h3C);
		send_item(br1rd_pkg::CMD_DATA, 8'hFF);
		set_config(br1rd_pkg::MODE_BYTERUN1, 16'd128);
		send_item(br1rd_pkg::CMD_DATA, 8'h81);
		send_item(br1rd_pkg::CMD_DATA, 8'hC3);
		set_config(br1rd_pkg::MODE_BYTERUN1, 16'hFFFF);
		send_item(br1rd_pkg::CMD_DATA, 8'hFE);
		send_item(br1rd_pkg::CMD_DATA, 8'h01);
		send_item(br1rd_pkg::CMD_DATA, 8'h81);
		send_item(br1rd_pkg::CMD_END, 8'h00);
	endtask

	task automatic test_raw_copy();
		set_config(br1rd_pkg::MODE_RAW, 16'd2);
		send_item(br1rd_pkg::CMD_DATA, 8'h00);
		send_item(br1rd_pkg::CMD_DATA, 8'hFF);
		send_item(br1rd_pkg::CMD_END, 8'h00);
		send_item(br1rd_pkg::CMD_DATA, br1rd_pkg::CTRL_SKIP);
		send_item(br1rd_pkg::CMD_END, 8'h00);
	endtask

	task automatic test_bad_mode();
		set_config(8'd2, br1rd_pkg::BYTES_PER_ROW_RST);
		send_item(br1rd_pkg::CMD_DATA, 8'h12);
		send_item(br1rd_pkg::CMD_END, 8'h00);
		set_config(8'hFF, 16'd1);
		send_item(br1rd_pkg::CMD_DATA, 8'h00);
	endtask

	task automatic test_random_byterun(input logic [15:0] bpr, input int budget);
		int cnt;
		int pick;
		int room;
		int n;
		set_config(br1rd_pkg::MODE_BYTERUN1, bpr);
		cnt = 0;
		while (cnt < budget) begin
			pick = $urandom_range(0, 99);
			room = (int'(dec_row_left) < 128) ? int'(dec_row_left) : 128;
			if (dec_phase != br1rd_pkg::PH_CONTROL) begin
				send_item(br1rd_pkg::CMD_DATA, 8'($urandom));
				cnt++;
			end else if (pick < 6) begin
				send_item(br1rd_pkg::CMD_DATA, 8'($urandom));
				cnt++;
			end else if (pick < 9) begin
				send_item(br1rd_pkg::CMD_END, 8'($urandom));
				cnt++;
			end else if (pick < 12 && room < 128) begin
				send_item(br1rd_pkg::CMD_DATA, 8'(room));
				cnt++;
			end else if (pick < 15) begin
				send_item(br1rd_pkg::CMD_DATA, br1rd_pkg::CTRL_SKIP);
			end else if (pick < 20 && dec_row_left == row_len()) begin
				send_item(br1rd_pkg::CMD_END, 8'($urandom));
			end else begin
				n = ($urandom_range(0, 4) != 0) ? $urandom_range(1, (room < 8) ? room : 8) :
					$urandom_range(1, room);
				if (n == 1 || $urandom_range(0, 1) == 0) begin
					send_item(br1rd_pkg::CMD_DATA, 8'(n - 1));
					repeat (n) send_item(br1rd_pkg::CMD_DATA, 8'($urandom));
					cnt += n + 1;
				end else begin
					send_item(br1rd_pkg::CMD_DATA, 8'(257 - n));
					send_item(br1rd_pkg::CMD_DATA, 8'($urandom));
					cnt += 2;
				end
			end
		end
	endtask

	task automatic test_random_raw(input logic [15:0] bpr, input int budget);
		set_config(br1rd_pkg::MODE_RAW, bpr);
		repeat (budget) begin
			if ($urandom_range(0, 19) == 0)
				send_item(br1rd_pkg::CMD_END, 8'($urandom));
			else
				send_item(br1rd_pkg::CMD_DATA, 8'($urandom));
		end
	endtask

	task automatic test_random_bad_mode(input logic [7:0] mode, input int budget);
		set_config(mode, 16'($urandom));
		repeat (budget) send_item(1'($urandom_range(0, 1)), 8'($urandom));
	endtask

	function automatic void check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] got);
		if (got !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				$error("result with none pending: byte_first %0h, status %0d",
					byte_first, status);
				fail_count++;
			end else begin
				want = decoded_q.pop_front();
				check_field("byte_first", want.byte_first, byte_first);
				check_field("byte_second", want.byte_second, byte_second);
				check_field("valid_count", 8'(want.valid_count), 8'(valid_count));
				check_field("row_end", 8'(want.row_end), 8'(row_end));
				check_field("status", 8'(want.status), 8'(status));
				check_field("last", 8'(want.last), 8'(last));
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		rx_tick <= rx_tick + 10'd1;
		case (rx_tick[9:7])
			3'd0, 3'd4: out_ready <= 1'b1;
			3'd1: out_ready <= 1'($urandom_range(0, 1));
			3'd2: out_ready <= (rx_tick[1:0] != 2'd0);
			3'd3: out_ready <= ($urandom_range(0, 3) == 0);
			3'd5: out_ready <= rx_tick[2];
			default: out_ready <= ($urandom_range(0, 4) != 0);
		endcase
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		restart_row();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_row_limits();
		test_raw_copy();
		test_bad_mode();
		test_random_byterun(br1rd_pkg::BYTES_PER_ROW_RST, 60);
		test_random_byterun(16'd1, 40);
		test_random_byterun(16'd0, 30);
		test_random_byterun(16'd5, 50);
		test_random_raw(16'($urandom_range(1, 20)), 50);
		test_random_byterun(16'd128, 60);
		test_random_bad_mode(8'($urandom_range(2, 255)), 10);
		test_random_byterun(16'hFFFF, 50);
		test_random_raw(16'hFFFF, 20);
		test_random_byterun(16'($urandom_range(2, 300)), 50);
		test_random_bad_mode(8'hFF, 10);
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (decoded_q.size() != 0) begin
			$error("%0d results never arrived", decoded_q.size());
			fail_count++;
		end
		$display("tb: %0d items sent, %0d results checked, %0d register writes",
			items_sent, results_checked, writes_done);
		$display("tb: %0d rows completed, %0d error results, raw/ByteRun1/bad modes exercised",
			rows_done, errors_predicted);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: byterun1_row_decoder_top.f
rtl/core/br1rd_pkg.sv
rtl/core/br1rd_ctrl.sv
rtl/core/br1rd_dpath.sv
rtl/core/byterun1_row_decoder_top.sv
sim/byterun1_row_decoder_top_tb.sv
